// ----- hdl/fau_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fau_pkg
// shared types and operation codes for the fraction arithmetic unit
// ----------------------------------------------------------------------------
package fau_pkg;

	localparam int OpW  = 3;
	localparam int InW  = 16;
	localparam int NumW = 33;
	localparam int DenW = 32;

	localparam logic [OpW-1:0] OP_ADD = 3'd0;
	localparam logic [OpW-1:0] OP_SUB = 3'd1;
	localparam logic [OpW-1:0] OP_MUL = 3'd2;
	localparam logic [OpW-1:0] OP_DIV = 3'd3;
	localparam logic [OpW-1:0] OP_SIMP = 3'd4;

	typedef struct packed {
		logic [OpW-1:0]    operation;
		logic signed [InW-1:0] a_num;
		logic signed [InW-1:0] a_den;
		logic signed [InW-1:0] b_num;
		logic signed [InW-1:0] b_den;
	} in_word_t;

	typedef struct packed {
		logic signed [NumW-1:0] res_num;
		logic signed [DenW-1:0] res_den;
		logic                   status;
	} out_word_t;

	// classified command handed from front to back
	typedef struct packed {
		logic                  simp;
		logic                  bad_op;
		logic [OpW-1:0]        operation;
		logic signed [InW-1:0] a_num;
		logic signed [InW-1:0] a_den;
		logic signed [InW-1:0] b_num;
		logic signed [InW-1:0] b_den;
	} cmd_t;

endpackage
`default_nettype wire

// ----- hdl/fau_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fau_front
// accepts input words, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module fau_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire fau_pkg::in_word_t in_data,
	output logic                  cmd_valid,
	input  wire logic             cmd_take,
	output fau_pkg::cmd_t         cmd_data
);
	import fau_pkg::*;

	localparam int Depth = 2;

	cmd_t          fifo_q [Depth];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	cmd_t          c;
	logic          push, pop;

	always_comb begin
		c.operation = in_data.operation;
		c.a_num = in_data.a_num;
		c.a_den = in_data.a_den;
		c.b_num = in_data.b_num;
		c.b_den = in_data.b_den;
		c.simp = (in_data.operation == OP_SIMP);
		c.bad_op = (in_data.operation > OP_SIMP);
	end

	assign in_stall  = (cnt_q == 2'(Depth));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd_data  = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// ----- hdl/fau_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fau_divider
// bit-serial truncating signed divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fau_divider #(
	parameter int W = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic signed [W-1:0] dividend,
	input  wire logic signed [W-1:0] divisor,
	output logic                     busy,
	output logic signed [W:0]        quot,
	output logic signed [W-1:0]      rem
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  q_q, d_q;
	logic [W:0]    r_q;
	logic [CW-1:0] cnt_q;
	logic          qneg_q, rneg_q;
	logic [W:0]    shifted, trial;

	assign shifted = {r_q[W-1:0], q_q[W-1]};
	assign trial   = shifted - {1'b0, d_q};
	assign busy    = (cnt_q != '0);
	// one extra bit so that the most negative value over minus one fits
	assign quot    = qneg_q ? (W+1)'(-{1'b0, q_q}) : {1'b0, q_q};
	assign rem     = rneg_q ? W'(-r_q[W-1:0]) : r_q[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend[W-1] ? W'(-dividend) : dividend;
			d_q <= divisor[W-1] ? W'(-divisor) : divisor;
			r_q <= '0;
			qneg_q <= dividend[W-1] ^ divisor[W-1];
			rneg_q <= dividend[W-1];
		end else if (busy) begin
			if (!trial[W]) begin
				r_q <= trial;
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= shifted;
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/fau_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fau_back
// executes one command: bad-op error, cross products or euclidean reduction
// ----------------------------------------------------------------------------
module fau_back #(
	parameter int W = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_take,
	input  wire fau_pkg::cmd_t     cmd_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output fau_pkg::out_word_t     out_data
);
	import fau_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_P1   = 3'd1;
	localparam logic [2:0] S_P2   = 3'd2;
	localparam logic [2:0] S_GCD  = 3'd3;
	localparam logic [2:0] S_QN   = 3'd4;
	localparam logic [2:0] S_QD   = 3'd5;
	localparam logic [2:0] S_WAIT = 3'd6;

	logic [2:0]            st_q;
	cmd_t                  c_q;
	logic signed [W-1:0]   an, ad, bn, bd;
	logic signed [W-1:0]   x_q, y_q;
	logic signed [W:0]     qn_q;
	logic signed [2*W-1:0] p1_q, p2_q, m1, m2;
	logic signed [W-1:0]   ma, mb, mc, md;
	logic                  dstart, dbusy, dwait_q;
	logic signed [W-1:0]   dnd, dvs, dr;
	logic signed [W:0]     dq;
	logic signed [NumW-1:0] num;
	logic signed [DenW-1:0] den;
	logic                  bad;

	assign an = W'(c_q.a_num);
	assign ad = W'(c_q.a_den);
	assign bn = W'(c_q.b_num);
	assign bd = W'(c_q.b_den);

	// phase one: numerator products, phase two: denominator product
	always_comb begin
		ma = an; mb = bd; mc = bn; md = ad;
		if (c_q.operation == OP_MUL) begin
			mb = bn; mc = '0;
		end
		if (c_q.operation == OP_DIV) mc = '0;
		if (st_q == S_P2) begin
			ma = ad;
			mb = (c_q.operation == OP_DIV) ? bn : bd;
			mc = '0;
		end
	end
	assign m1 = ma * mb;
	assign m2 = mc * md;

	always_comb begin
		num = (c_q.operation == OP_SUB) ?
			NumW'(p1_q) - NumW'(p2_q) : NumW'(p1_q) + NumW'(p2_q);
		den = DenW'(m1);
		bad = (ad == '0) || (bd == '0) || (den == '0);
	end

	always_comb begin
		dnd = x_q; dvs = y_q;
		if (st_q == S_QN) begin
			dnd = an; dvs = x_q;
		end
		if (st_q == S_QD) begin
			dnd = ad; dvs = x_q;
		end
	end

	fau_divider #(.W(W)) u_div (
		.clk, .arst_n, .start(dstart), .dividend(dnd), .divisor(dvs),
		.busy(dbusy), .quot(dq), .rem(dr)
	);

	assign cmd_take = (st_q == S_IDLE) && cmd_valid && !out_valid;

	always_comb begin
		dstart = 1'b0;
		if (st_q == S_GCD && !dbusy && !dwait_q && y_q != '0) dstart = 1'b1;
		if (st_q == S_QN && !dbusy && !dwait_q) dstart = 1'b1;
		if (st_q == S_QD && !dbusy && !dwait_q) dstart = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd_take) c_q <= cmd_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid <= 1'b0;
			dwait_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (cmd_take) begin
						if (cmd_data.bad_op) begin
							out_data <= '{res_num: '0, res_den: '0, status: 1'b1};
							out_valid <= 1'b1;
						end else if (cmd_data.simp) begin
							x_q <= W'(cmd_data.a_num);
							y_q <= W'(cmd_data.a_den);
							dwait_q <= 1'b0;
							st_q <= S_GCD;
						end else begin
							st_q <= S_P1;
						end
					end
				end
				S_P1: begin
					p1_q <= m1; p2_q <= m2;
					st_q <= S_P2;
				end
				S_P2: begin
					out_data <= '{res_num: num, res_den: den, status: bad};
					out_valid <= 1'b1;
					st_q <= S_IDLE;
				end
				S_GCD: begin
					// one remainder step per divider pass
					if (dstart) begin
						dwait_q <= 1'b1;
					end else if (dwait_q && !dbusy) begin
						dwait_q <= 1'b0;
						x_q <= y_q;
						y_q <= dr;
					end else if (!dwait_q && y_q == '0) begin
						if (x_q == '0) begin
							out_data <= '{res_num: '0, res_den: '0, status: 1'b1};
							out_valid <= 1'b1;
							st_q <= S_IDLE;
						end else begin
							st_q <= S_QN;
						end
					end
				end
				S_QN: begin
					// numerator quotient computed first, kept in qn_q
					if (dstart) begin
						dwait_q <= 1'b1;
					end else if (dwait_q && !dbusy) begin
						dwait_q <= 1'b0;
						qn_q <= dq;
						st_q <= S_QD;
					end
				end
				S_QD: begin
					if (dstart) begin
						dwait_q <= 1'b1;
					end else if (dwait_q && !dbusy) begin
						dwait_q <= 1'b0;
						out_data <= '{res_num: NumW'(qn_q), res_den: DenW'(dq),
							status: (dq == '0)};
						out_valid <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/fraction_arithmetic_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fraction_arithmetic_unit
// signed fraction add, subtract, multiply, divide and gcd reduction
// ----------------------------------------------------------------------------
// add, subtract, multiply and divide pass through the P1 and P2 states of the
// back end. simplify runs the euclidean loop on a shared bit-serial divider,
// one divider pass per remainder step, then two quotient divisions. a two-word
// queue decouples input from the back end; one result is held in the output
// register until taken.
module fraction_arithmetic_unit #(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire fau_pkg::in_word_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output fau_pkg::out_word_t      out_data
);
	import fau_pkg::*;

	logic cmd_valid, cmd_take;
	cmd_t cmd_data;

	fau_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.cmd_valid, .cmd_take, .cmd_data
	);

	fau_back #(.W(OPERAND_WIDTH)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd_data,
		.out_valid, .out_stall, .out_data
	);
endmodule
`default_nettype wire

// ----- dv/fau_checker.sv -----
// ----------------------------------------------------------------------------
// fau_checker
// watches both channels of the fraction unit, predicts each result word and
// compares the whole word with what the block delivers
// ----------------------------------------------------------------------------
module fau_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire fau_pkg::in_word_t  in_data,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire fau_pkg::out_word_t out_data,
	output int                      fail_count,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import fau_pkg::*;

	out_word_t expected_results[$];

	function automatic out_word_t fraction_result(in_word_t w);
		out_word_t r;
		longint an, ad, bn, bd, num, den, x, y, t, qn, qd;
		an = w.a_num;
		ad = w.a_den;
		bn = w.b_num;
		bd = w.b_den;
		num = 0;
		den = 0;
		r.status = 1'b1;
		case (w.operation)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				den = ad * bd;
				if (w.operation == OP_ADD) num = an * bd + bn * ad;
				else if (w.operation == OP_SUB) num = an * bd - bn * ad;
				else if (w.operation == OP_MUL) num = an * bn;
				else begin
					num = an * bd;
					den = ad * bn;
				end
				r.status = (ad == 0) || (bd == 0) || (den[31:0] == 32'd0);
			end
			OP_SIMP: begin
				x = an;
				y = ad;
				// truncating remainder, so the sign of the remainder follows the dividend
				while (y != 0) begin
					t = x % y;
					x = y;
					y = t;
				end
				if (x != 0) begin
					qn = an / x;
					qd = ad / x;
					num = qn;
					den = qd;
					r.status = (qd == 0);
				end
			end
			default: ;
		endcase
		r.res_num = num[NumW-1:0];
		r.res_den = den[DenW-1:0];
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			fail_count <= 0;
			expected_results.delete();
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(fraction_result(in_data));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result word num=%0d den=%0d status=%0b",
							out_data.res_num, out_data.res_den, out_data.status);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_results.pop_front();
					if (e !== out_data) begin
						if (fail_count < 10)
							$display("mismatch: expected num=%0d den=%0d status=%0b, got num=%0d den=%0d status=%0b",
								e.res_num, e.res_den, e.status,
								out_data.res_num, out_data.res_den, out_data.status);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ----- dv/fraction_arithmetic_unit_tb.sv -----
// ----------------------------------------------------------------------------
// fraction_arithmetic_unit_tb
// directed extremes and special cases, then random fraction words with
// bursty input and patterned output stalls; verdict from the checker count
// ----------------------------------------------------------------------------
module fraction_arithmetic_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fau_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_data;
	int        fail_count;
	int        pending;
	in_word_t  directed_words[$];

	always #6 clk = ~clk;

	fraction_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	fau_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	function automatic logic [15:0] operand_value();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 8)) - 4);
			4, 5: return 16'(int'($urandom_range(0, 60)) - 30);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		int common;
		w.operation = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
			: 3'($urandom_range(0, 4));
		w.a_num = operand_value();
		w.a_den = operand_value();
		w.b_num = operand_value();
		w.b_den = operand_value();
		// shared factors so that reduction has real work to do
		if (w.operation == OP_SIMP && $urandom_range(0, 1)) begin
			common = $urandom_range(1, 200);
			w.a_num = 16'(int'($urandom_range(0, 160)) - 80) * 16'(common);
			w.a_den = 16'(int'($urandom_range(0, 160)) - 80) * 16'(common);
		end
		return w;
	endfunction

	// output stall pattern: long free runs mixed with heavy stalling
	initial begin
		int phase;
		phase = 0;
		forever begin
			@(posedge clk);
			phase = (phase + 1) % 400;
			if (phase < 100) out_stall <= 1'b0;
			else if (phase < 250) out_stall <= ($urandom_range(0, 3) == 0);
			else out_stall <= ($urandom_range(0, 1) == 0);
		end
	end

	initial begin
		#50ms;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		in_word_t w;
		int burst;
		int gap;
		int total;
		int wait_cycles;
		logic [2:0] op_code;

		for (int k = 0; k < 8; k++) begin
			op_code = 3'(k);
			w = '{op_code, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff};
			directed_words.push_back(w);
		end
		directed_words.push_back('{OP_SIMP, 16'sd5, 16'sd0, 16'sd0, 16'sd0});
		directed_words.push_back('{OP_SIMP, 16'sd0, 16'sd0, 16'sd1, 16'sd1});
		directed_words.push_back('{OP_SIMP, 16'sd0, -16'sd7, 16'sd1, 16'sd1});
		directed_words.push_back('{OP_SIMP, -16'sd12, 16'sd18, 16'sd0, 16'sd0});
		directed_words.push_back('{OP_SIMP, 16'sh8000, 16'sh8000, 16'shffff, 16'shffff});
		directed_words.push_back('{OP_SIMP, 16'sd6765, 16'sd10946, 16'sd0, 16'sd0});
		directed_words.push_back('{OP_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd2});
		directed_words.push_back('{OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd0});
		directed_words.push_back('{OP_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5});
		directed_words.push_back('{OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
		directed_words.push_back('{OP_ADD, 16'shffff, 16'shffff, 16'shffff, 16'shffff});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		total = 0;
		while (total < 1600 + directed_words.size()) begin
			burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
			for (int k = 0; k < burst; k++) begin
				in_valid <= 1'b1;
				in_data <= (total < directed_words.size()) ? directed_words[total]
					: random_word();
				total++;
				@(posedge clk);
				while (in_stall) @(posedge clk);
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/fau_pkg.sv
hdl/fau_front.sv
hdl/fau_divider.sv
hdl/fau_back.sv
hdl/fraction_arithmetic_unit.sv
dv/fau_checker.sv
dv/fraction_arithmetic_unit_tb.sv
